### rtl/core/coalesced_hash_table_macros.svh
// Assertion macros shared by the checker.
`ifndef COALESCED_HASH_TABLE_MACROS_SVH
`define COALESCED_HASH_TABLE_MACROS_SVH
// Assert that a property holds at each rising edge outside reset.
`define CHT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert that a property holds at each rising edge, reset included.
`define CHT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### rtl/core/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and codes of the coalesced hash table.
// ----------------------------------------------------------------------------
package cht_pkg;
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam int KEY_W = 31;
  localparam int SLOT_OUT_W = 4;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [SLOT_OUT_W-1:0] slot;
  } rsp_t;
endpackage

### rtl/core/cht_req_if.sv
// ----------------------------------------------------------------------------
// cht_req_if
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface cht_req_if;
  logic          valid;
  logic          ready;
  cht_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/cht_rsp_if.sv
// ----------------------------------------------------------------------------
// cht_rsp_if
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface cht_rsp_if;
  logic          valid;
  logic          ready;
  cht_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/cht_ram.sv
// ----------------------------------------------------------------------------
// cht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/coalesced_hash_table.sv
// ----------------------------------------------------------------------------
// coalesced_hash_table
// Coalesced hash table with linear probing, held in a key RAM.
// ----------------------------------------------------------------------------
// One operation at a time. Each linear probe and each search link step
// issues a key-RAM read and then evaluates the registered data. The
// delete chain walk and the link sweep run over flip-flops at one step a
// cycle. Insert probes up to SLOTS slots. Search probes up to SLOTS slots
// for the chain head and then follows up to SLOTS-1 links. Delete probes
// up to SLOTS slots for the key, follows the chain to its tail and then
// either moves the tail key or sweeps all SLOTS link entries to cut any
// link into the freed slot. Occupancy bits and links sit in flip-flops
// (reset clears them at once); keys live in one RAM that needs no
// clearing, since only the keys of occupied slots are ever used. The
// result word waits in an output register; a new word is taken only after
// it has left. The SLOTS parameter must be a power of two.
module coalesced_hash_table #(
  parameter int SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  cht_req_if.sink   in_ch,
  cht_rsp_if.source out_ch
);
  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int LW = AW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_EVAL  = 4'd2;
  localparam logic [3:0] S_CUT   = 4'd3;
  localparam logic [3:0] S_MOVE  = 4'd4;
  localparam logic [3:0] S_OUT   = 4'd5;

  // Phases inside a walk.
  localparam logic [1:0] PH_PROBE = 2'd0;  // linear probe
  localparam logic [1:0] PH_CHAIN = 2'd1;  // follow links
  localparam logic [1:0] PH_TAILK = 2'd2;  // read tail key for delete move

  logic [3:0]               state_r, state_nxt;
  logic [1:0]               ph_r, ph_nxt;
  logic [1:0]               op_r, op_nxt;
  logic [cht_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic [AW-1:0]            tgt_r, tgt_nxt;
  logic [AW-1:0]            pre_r, pre_nxt;
  logic                     pre_ok_r, pre_ok_nxt;
  logic [CW-1:0]            n_r, n_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [SLOTS-1:0]         used_r, used_nxt;
  logic [LW-1:0]            link_r [SLOTS];
  logic [LW-1:0]            link_nxt [SLOTS];
  cht_pkg::rsp_t            rsp_r, rsp_nxt;
  logic                     ov_r, ov_nxt;

  logic                     we;
  logic [AW-1:0]            waddr, raddr;
  logic [cht_pkg::KEY_W-1:0] wdata, rdata;

  cht_ram #(.WIDTH(cht_pkg::KEY_W), .DEPTH(SLOTS)) u_keys (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_ch.ready  = (state_r == S_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.data  = rsp_r;

  logic [AW-1:0] home;
  logic [LW-1:0] lnk;
  assign home = key_r[AW-1:0];
  assign lnk  = link_r[pos_r];

  always_comb begin
    state_nxt = state_r; ph_nxt = ph_r; op_nxt = op_r; key_nxt = key_r;
    pos_nxt = pos_r; tgt_nxt = tgt_r; pre_nxt = pre_r; pre_ok_nxt = pre_ok_r;
    n_nxt = n_r; cnt_nxt = cnt_r; used_nxt = used_r; link_nxt = link_r;
    rsp_nxt = rsp_r; ov_nxt = ov_r;
    we = 1'b0; waddr = pos_r; wdata = key_r; raddr = pos_r;
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && !ov_r) begin
          op_nxt = in_ch.data.op; key_nxt = in_ch.data.key;
          pos_nxt = in_ch.data.key[AW-1:0];
          n_nxt = '0; pre_ok_nxt = 1'b0; ph_nxt = PH_PROBE;
          rsp_nxt = '{status: cht_pkg::ST_NOT_FOUND, slot: '0};
          state_nxt = S_OUT;
          case (in_ch.data.op)
            cht_pkg::OP_INSERT: begin
              if (cnt_r >= CW'(SLOTS)) begin
                rsp_nxt.status = cht_pkg::ST_FULL;
              end else begin
                state_nxt = S_RD;
              end
            end
            cht_pkg::OP_DELETE: begin
              if (cnt_r == '0) begin
                rsp_nxt.status = cht_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_RD;
              end
            end
            cht_pkg::OP_SEARCH: state_nxt = S_RD;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_RD: begin
        raddr = pos_r;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_RD;
        if (ph_r == PH_TAILK) begin
          // Move tail key into the freed position, unlink and free the tail.
          we = 1'b1; waddr = tgt_r; wdata = rdata;
          link_nxt[pre_r] = '1;
          used_nxt[pos_r] = 1'b0;
          link_nxt[pos_r] = '1;
          cnt_nxt = cnt_r - 1'b1;
          rsp_nxt = '{status: cht_pkg::ST_DONE, slot: cht_pkg::SLOT_OUT_W'(tgt_r)};
          state_nxt = S_OUT;
        end else if (ph_r == PH_PROBE) begin
          case (op_r)
            cht_pkg::OP_INSERT: begin
              if (!used_r[pos_r]) begin
                we = 1'b1; waddr = pos_r; wdata = key_r;
                used_nxt[pos_r] = 1'b1;
                link_nxt[pos_r] = '1;
                if (pre_ok_r) begin
                  link_nxt[pre_r] = LW'(pos_r);
                end
                cnt_nxt = cnt_r + 1'b1;
                rsp_nxt = '{status: cht_pkg::ST_DONE,
                            slot: cht_pkg::SLOT_OUT_W'(pos_r)};
                state_nxt = S_OUT;
              end else begin
                if (rdata[AW-1:0] == home) begin
                  pre_nxt = pos_r; pre_ok_nxt = 1'b1;
                end
                pos_nxt = pos_r + 1'b1; n_nxt = n_r + 1'b1;
                if (n_r == CW'(SLOTS - 1)) begin
                  rsp_nxt.status = cht_pkg::ST_FULL;
                  state_nxt = S_OUT;
                end
              end
            end
            cht_pkg::OP_DELETE: begin
              if (used_r[pos_r] && rdata == key_r) begin
                tgt_nxt = pos_r; n_nxt = '0; pre_ok_nxt = 1'b0;
                ph_nxt = PH_CHAIN;
                state_nxt = S_MOVE;
              end else begin
                pos_nxt = pos_r + 1'b1; n_nxt = n_r + 1'b1;
                if (n_r == CW'(SLOTS - 1)) state_nxt = S_OUT;
              end
            end
            default: begin
              if (used_r[pos_r] && rdata[AW-1:0] == home) begin
                ph_nxt = PH_CHAIN; n_nxt = '0;
                // Same read holds the head key: check it now.
                if (rdata == key_r) begin
                  rsp_nxt = '{status: cht_pkg::ST_DONE,
                              slot: cht_pkg::SLOT_OUT_W'(pos_r)};
                  state_nxt = S_OUT;
                end else if (lnk[AW] || !used_r[lnk[AW-1:0]]) begin
                  state_nxt = S_OUT;
                end else begin
                  pos_nxt = lnk[AW-1:0]; n_nxt = CW'(1);
                end
              end else begin
                pos_nxt = pos_r + 1'b1; n_nxt = n_r + 1'b1;
                if (n_r == CW'(SLOTS - 1)) state_nxt = S_OUT;
              end
            end
          endcase
        end else begin
          // Search chain walk; position is occupied here.
          if (rdata == key_r) begin
            rsp_nxt = '{status: cht_pkg::ST_DONE, slot: cht_pkg::SLOT_OUT_W'(pos_r)};
            state_nxt = S_OUT;
          end else if (lnk[AW] || !used_r[lnk[AW-1:0]] || n_r == CW'(SLOTS - 1)) begin
            state_nxt = S_OUT;
          end else begin
            pos_nxt = lnk[AW-1:0]; n_nxt = n_r + 1'b1;
          end
        end
      end
      S_MOVE: begin
        // Walk delete chain from target to tail over link flops, one step a cycle.
        if (lnk[AW] || !used_r[lnk[AW-1:0]] || n_r == CW'(SLOTS)) begin
          if (pos_r == tgt_r || !pre_ok_r) begin
            n_nxt = '0; state_nxt = S_CUT;
          end else begin
            ph_nxt = PH_TAILK; state_nxt = S_RD;
          end
        end else begin
          pre_nxt = pos_r; pre_ok_nxt = 1'b1;
          pos_nxt = lnk[AW-1:0]; n_nxt = n_r + 1'b1;
        end
      end
      S_CUT: begin
        // Sweep links, drop any that name the freed slot.
        if (link_r[n_r[AW-1:0]] == LW'(tgt_r)) begin
          link_nxt[n_r[AW-1:0]] = '1;
        end
        n_nxt = n_r + 1'b1;
        if (n_r == CW'(SLOTS - 1)) begin
          used_nxt[tgt_r] = 1'b0;
          link_nxt[tgt_r] = '1;
          cnt_nxt = cnt_r - 1'b1;
          rsp_nxt = '{status: cht_pkg::ST_DONE, slot: cht_pkg::SLOT_OUT_W'(tgt_r)};
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0; cnt_r <= '0; used_r <= '0;
      for (int i = 0; i < SLOTS; i++) link_r[i] <= '1;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt; cnt_r <= cnt_nxt; used_r <= used_nxt;
      link_r <= link_nxt;
    end
    ph_r <= ph_nxt; op_r <= op_nxt; key_r <= key_nxt; pos_r <= pos_nxt;
    tgt_r <= tgt_nxt; pre_r <= pre_nxt; pre_ok_r <= pre_ok_nxt; n_r <= n_nxt;
    rsp_r <= rsp_nxt;
  end
endmodule

### rtl/core/cht_checker.sv
// ----------------------------------------------------------------------------
// cht_checker
// Port-level checks of the coalesced hash table, bound to the top level.
// ----------------------------------------------------------------------------
`include "coalesced_hash_table_macros.svh"
module cht_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input cht_pkg::rsp_t out_data
);
  `CHT_ASSERT(a_slot_zero, clk, rst_n, out_valid && out_data.status != cht_pkg::ST_DONE |-> out_data.slot == '0, "slot not zero on failure")
  `CHT_ASSERT(a_no_take_while_out, clk, rst_n, out_valid |-> !in_ready, "input taken while result pending")
  `CHT_ASSERT(a_take_no_out, clk, rst_n, in_valid && in_ready |=> !out_valid, "result before work")
  `CHT_ASSERT(a_hold_result, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "waiting result changed")
  `CHT_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "result after reset")
endmodule

bind coalesced_hash_table cht_checker u_cht_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
